// File: sv/brle8_pkg.sv
// ----------------------------------------------------------------------------
// brle8_pkg
// Shared widths, register indexes, reset values and control types for the
// BMP RLE8 decoder.
// ----------------------------------------------------------------------------
package brle8_pkg;

    localparam int BYTE_W  = 8;
    localparam int CUR_W   = 11;
    localparam int POS_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CUR_W-1:0] MAX_SIDE   = 11'd1024;
    localparam logic [CUR_W-1:0] CUR_MAX    = 11'd2047;
    localparam logic [CUR_W-1:0] WIDTH_MIN  = 11'd8;
    localparam logic [CUR_W-1:0] HEIGHT_MIN = 11'd1;
    localparam logic [CUR_W-1:0] WIDTH_RST  = 11'd320;
    localparam logic [CUR_W-1:0] HEIGHT_RST = 11'd200;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        logic load_run;
        logic start_run;
        logic start_lit;
        logic load_lit;
        logic dec_lit;
        logic clear_pad;
        logic load_dx;
        logic apply_delta;
        logic newline;
        logic fill_step;
        logic clear_all;
    } t_cmd;

    typedef struct packed {
        logic run_zero;
        logic lit_one;
        logic pad;
        logic out_free;
        logic fill_done;
    } t_sts;

    function automatic logic [CUR_W-1:0] clamp_side(input logic [CUR_W-1:0] v,
                                                    input logic [CUR_W-1:0] lo);
        logic [CUR_W-1:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > MAX_SIDE) r = MAX_SIDE;
        return r;
    endfunction

endpackage

// File: sv/brle8_ifs.sv
// ----------------------------------------------------------------------------
// brle8 channel interfaces
// Byte input, segment output and register write channels.
// ----------------------------------------------------------------------------
interface brle8_in_if;
    logic                          valid;
    logic                          ready;
    logic [brle8_pkg::BYTE_W-1:0]  data_byte;
    logic                          end_of_data;
    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface brle8_out_if;
    logic                          valid;
    logic                          ready;
    logic [brle8_pkg::POS_W-1:0]   row;
    logic [brle8_pkg::POS_W-1:0]   column;
    logic [brle8_pkg::BYTE_W-1:0]  length;
    logic [brle8_pkg::BYTE_W-1:0]  pixel;
    logic                          last;
    modport source (output valid, row, column, length, pixel, last, input ready);
    modport sink   (input valid, row, column, length, pixel, last, output ready);
endinterface

interface brle8_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [brle8_pkg::CFG_IDX_W-1:0]  index;
    logic [brle8_pkg::CUR_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/bmp_rle8_decoder.sv
// A segment appears on the output in the cycle after the cycle that cuts it.
// A literal byte is accepted and then filled as a one-pixel segment; a run byte is cut
// into row segments (1 to 33) by the segment splitter, which produces one segment per
// cycle into the output register while that register is free.
// Reset is synchronous, active low: parser and cursor clear, width 320, height 200.
// ----------------------------------------------------------------------------
// bmp_rle8_decoder
// BMP RLE8 stream decoder producing row fill segments.
// ----------------------------------------------------------------------------
module bmp_rle8_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brle8_in_if.sink    i_in,
    brle8_out_if.source o_out,
    brle8_cfg_if.sink   i_cfg
);

    brle8_pkg::t_cmd w_cmd;
    brle8_pkg::t_sts w_sts;

    brle8_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_data_byte   (i_in.data_byte),
        .i_end_of_data (i_in.end_of_data),
        .o_cmd         (w_cmd),
        .i_sts         (w_sts)
    );

    brle8_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_row       (o_out.row),
        .o_column    (o_out.column),
        .o_length    (o_out.length),
        .o_pixel     (o_out.pixel),
        .o_last      (o_out.last)
    );

endmodule

// File: sv/brle8_ctrl.sv
// ----------------------------------------------------------------------------
// brle8_ctrl
// Stream parser state machine; sequences fills one segment per cycle while the output register is free.
// ----------------------------------------------------------------------------
module brle8_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [brle8_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                         i_end_of_data,
    output brle8_pkg::t_cmd              o_cmd,
    input  brle8_pkg::t_sts              i_sts
);

    localparam logic [2:0] S_COUNT = 3'd0;
    localparam logic [2:0] S_VALUE = 3'd1;
    localparam logic [2:0] S_DX    = 3'd2;
    localparam logic [2:0] S_DY    = 3'd3;
    localparam logic [2:0] S_LIT   = 3'd4;
    localparam logic [2:0] S_PAD   = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic       r_eod, n_eod;
    logic       w_acc;

    assign o_in_ready = (r_state != S_FILL);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_eod   = r_eod;
        o_cmd   = '0;
        if (r_state == S_FILL) begin
            if (i_sts.out_free) begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_done) begin
                    n_state         = r_eod ? S_COUNT : r_ret;
                    o_cmd.clear_all = r_eod;
                    n_eod           = 1'b0;
                end
            end
        end else if (w_acc) begin
            unique case (r_state)
                S_VALUE: begin
                    n_state = S_COUNT;
                    if (!i_sts.run_zero) begin
                        o_cmd.start_run = 1'b1;
                        n_ret           = S_COUNT;
                        n_state         = S_FILL;
                        n_eod           = i_end_of_data;
                    end else if (i_data_byte == brle8_pkg::ESC_EOL) begin
                        o_cmd.newline = 1'b1;
                    end else if (i_data_byte == brle8_pkg::ESC_EOB) begin
                        n_state = S_COUNT;
                    end else if (i_data_byte == brle8_pkg::ESC_DELTA) begin
                        n_state = S_DX;
                    end else begin
                        o_cmd.load_lit = 1'b1;
                        n_state        = S_LIT;
                    end
                end
                S_DX: begin
                    o_cmd.load_dx = 1'b1;
                    n_state       = S_DY;
                end
                S_DY: begin
                    o_cmd.apply_delta = 1'b1;
                    n_state           = S_COUNT;
                end
                S_LIT: begin
                    o_cmd.start_lit = 1'b1;
                    o_cmd.dec_lit   = 1'b1;
                    if (i_sts.lit_one) begin
                        n_ret = i_sts.pad ? S_PAD : S_COUNT;
                    end else begin
                        n_ret = S_LIT;
                    end
                    n_state = S_FILL;
                    n_eod   = i_end_of_data;
                end
                S_PAD: begin
                    o_cmd.clear_pad = 1'b1;
                    n_state         = S_COUNT;
                end
                default: begin
                    o_cmd.load_run = 1'b1;
                    n_state        = S_VALUE;
                end
            endcase
            if (i_end_of_data && n_state != S_FILL) begin
                o_cmd.clear_all = 1'b1;
                n_state         = S_COUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COUNT;
            r_ret   <= S_COUNT;
            r_eod   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_eod   <= n_eod;
        end
    end

endmodule

// File: sv/brle8_dp.sv
// ----------------------------------------------------------------------------
// brle8_dp
// Cursor, parser registers, segment splitter and output register.
// ----------------------------------------------------------------------------
module brle8_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [brle8_pkg::BYTE_W-1:0]    i_data_byte,
    input  brle8_pkg::t_cmd                 i_cmd,
    output brle8_pkg::t_sts                 o_sts,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brle8_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [brle8_pkg::CUR_W-1:0]     i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [brle8_pkg::POS_W-1:0]     o_row,
    output logic [brle8_pkg::POS_W-1:0]     o_column,
    output logic [brle8_pkg::BYTE_W-1:0]    o_length,
    output logic [brle8_pkg::BYTE_W-1:0]    o_pixel,
    output logic                            o_last
);

    localparam int CW = brle8_pkg::CUR_W;
    localparam int BW = brle8_pkg::BYTE_W;
    localparam int PW = brle8_pkg::POS_W;

    logic [CW-1:0] r_width, r_height;
    logic [BW-1:0] r_run, r_lit, r_dx, r_cnt, r_pix;
    logic          r_pad;
    logic [CW-1:0] r_col, r_row;

    logic          r_ov;
    logic [PW-1:0] r_orow, r_ocol;
    logic [BW-1:0] r_olen, r_opix;
    logic          r_olast;

    logic [CW-1:0] w_hm1, w_nl_row, w_col_e, w_row_e, w_space, w_col_next;
    logic [CW:0]   w_row_inc, w_dcol, w_drow;
    logic [BW-1:0] w_n;
    logic          w_wrap, w_emit, w_done, w_out_free;

    assign o_cfg_ready = 1'b1;

    assign w_hm1     = r_height - 11'd1;
    assign w_row_inc = {1'b0, r_row} + 12'd1;
    assign w_nl_row  = (w_row_inc < {1'b0, w_hm1}) ? w_row_inc[CW-1:0] : w_hm1;

    assign w_wrap     = (r_col >= r_width);
    assign w_col_e    = w_wrap ? '0 : r_col;
    assign w_row_e    = w_wrap ? w_nl_row : r_row;
    assign w_space    = r_width - w_col_e;
    assign w_n        = (w_space > {3'b000, r_cnt}) ? r_cnt : w_space[BW-1:0];
    assign w_emit     = (w_row_e < r_height);
    assign w_done     = (w_n == r_cnt);
    assign w_col_next = w_col_e + {3'b000, w_n};

    assign w_dcol = {1'b0, r_col} + {4'b0000, r_dx};
    assign w_drow = {1'b0, r_row} + {4'b0000, i_data_byte};

    assign w_out_free = !r_ov || i_out_ready;

    assign o_sts.run_zero  = (r_run == '0);
    assign o_sts.lit_one   = (r_lit == 8'd1);
    assign o_sts.pad       = r_pad;
    assign o_sts.out_free  = w_out_free;
    assign o_sts.fill_done = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brle8_pkg::WIDTH_RST;
            r_height <= brle8_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brle8_pkg::REG_WIDTH:
                    r_width <= brle8_pkg::clamp_side(i_cfg_data, brle8_pkg::WIDTH_MIN);
                brle8_pkg::REG_HEIGHT:
                    r_height <= brle8_pkg::clamp_side(i_cfg_data, brle8_pkg::HEIGHT_MIN);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_lit <= '0;
            r_pad <= 1'b0;
            r_dx  <= '0;
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else if (i_cmd.clear_all) begin
            r_run <= '0;
            r_lit <= '0;
            r_pad <= 1'b0;
            r_dx  <= '0;
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load_run) r_run <= i_data_byte;
            if (i_cmd.load_lit) begin
                r_lit <= i_data_byte;
                r_pad <= i_data_byte[0];
            end
            if (i_cmd.dec_lit)   r_lit <= r_lit - 8'd1;
            if (i_cmd.clear_pad) r_pad <= 1'b0;
            if (i_cmd.load_dx)   r_dx  <= i_data_byte;
            if (i_cmd.start_run) r_cnt <= r_run;
            if (i_cmd.start_lit) r_cnt <= 8'd1;
            if (i_cmd.fill_step) r_cnt <= r_cnt - w_n;
            if (i_cmd.newline) begin
                r_col <= '0;
                r_row <= w_nl_row;
            end
            if (i_cmd.apply_delta) begin
                r_col <= w_dcol[CW] ? brle8_pkg::CUR_MAX : w_dcol[CW-1:0];
                r_row <= w_drow[CW] ? brle8_pkg::CUR_MAX : w_drow[CW-1:0];
            end
            if (i_cmd.fill_step) begin
                r_col <= w_col_next;
                r_row <= w_row_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_run || i_cmd.start_lit) r_pix <= i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fill_step && w_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step && w_emit) begin
            r_orow  <= w_row_e[PW-1:0];
            r_ocol  <= w_col_e[PW-1:0];
            r_olen  <= w_n;
            r_opix  <= r_pix;
            r_olast <= w_done;
        end
    end

    assign o_out_valid = r_ov;
    assign o_row       = r_orow;
    assign o_column    = r_ocol;
    assign o_length    = r_olen;
    assign o_pixel     = r_opix;
    assign o_last      = r_olast;

endmodule

// File: sv/brle8_chk.sv
// ----------------------------------------------------------------------------
// brle8_chk
// Port-level checks on the segment output of the decoder.
// ----------------------------------------------------------------------------
module brle8_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [brle8_pkg::POS_W-1:0]  i_row,
    input logic [brle8_pkg::POS_W-1:0]  i_column,
    input logic [brle8_pkg::BYTE_W-1:0] i_length,
    input logic [brle8_pkg::BYTE_W-1:0] i_pixel,
    input logic                         i_last
);

    logic [brle8_pkg::CUR_W-1:0] w_end;

    assign w_end = {1'b0, i_column} + {3'b000, i_length};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row)
            && $stable(i_column) && $stable(i_length) && $stable(i_pixel)
            && $stable(i_last))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_length != '0)
        else $error("zero length segment");

    a_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> w_end <= brle8_pkg::MAX_SIDE)
        else $error("segment runs past the row");

endmodule

bind bmp_rle8_decoder brle8_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_row       (o_out.row),
    .i_column    (o_out.column),
    .i_length    (o_out.length),
    .i_pixel     (o_out.pixel),
    .i_last      (o_out.last)
);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives RLE8 byte streams into bmp_rle8_decoder and checks every fill segment
// against a predictor of the stream parser and cursor. Short directed streams
// run first, then random escape, run and literal sequences under several image
// sizes and handshake idling mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          DRAIN_CYCLES = 40;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          MAX_PRINTED  = 30;
    localparam logic [7:0]  ESC_MARK     = 8'd0;

    typedef enum logic [2:0] {
        EXPECT_COUNT, EXPECT_VALUE, EXPECT_DX, EXPECT_DY, IN_LITERAL, EXPECT_PAD
    } t_parse;

    typedef struct packed {
        logic [brle8_pkg::POS_W-1:0]  row;
        logic [brle8_pkg::POS_W-1:0]  column;
        logic [brle8_pkg::BYTE_W-1:0] length;
        logic [brle8_pkg::BYTE_W-1:0] pixel;
        logic                         last;
    } t_segment;

    class t_seg_scoreboard;
        logic [brle8_pkg::CUR_W-1:0] width_reg;
        logic [brle8_pkg::CUR_W-1:0] height_reg;
        t_parse                      phase;
        logic [7:0]                  run_len;
        logic [7:0]                  lit_left;
        logic                        pad_due;
        logic [7:0]                  dx_hold;
        logic [brle8_pkg::CUR_W-1:0] col;
        logic [brle8_pkg::CUR_W-1:0] row;
        t_segment                    byte_segs[$];
        t_segment                    expected_segments[$];
        int                          mismatch_count;
        int                          checked;

        function new();
            width_reg      = brle8_pkg::WIDTH_RST;
            height_reg     = brle8_pkg::HEIGHT_RST;
            mismatch_count = 0;
            checked        = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            phase    = EXPECT_COUNT;
            run_len  = '0;
            lit_left = '0;
            pad_due  = 1'b0;
            dx_hold  = '0;
            col      = '0;
            row      = '0;
        endfunction

        function void set_register(logic [brle8_pkg::CFG_IDX_W-1:0] idx,
                                   logic [brle8_pkg::CUR_W-1:0] val);
            if (idx == brle8_pkg::REG_WIDTH) width_reg = val;
            else if (idx == brle8_pkg::REG_HEIGHT) height_reg = val;
        endfunction

        function int unsigned used_width();
            int unsigned w;
            w = width_reg;
            if (w < brle8_pkg::WIDTH_MIN) w = brle8_pkg::WIDTH_MIN;
            if (w > brle8_pkg::MAX_SIDE) w = brle8_pkg::MAX_SIDE;
            return w;
        endfunction

        function int unsigned used_height();
            int unsigned h;
            h = height_reg;
            if (h < brle8_pkg::HEIGHT_MIN) h = brle8_pkg::HEIGHT_MIN;
            if (h > brle8_pkg::MAX_SIDE) h = brle8_pkg::MAX_SIDE;
            return h;
        endfunction

        function void next_line();
            int unsigned h;
            int unsigned r;
            h   = used_height();
            r   = row + 1;
            col = '0;
            row = (r < h - 1) ? r[brle8_pkg::CUR_W-1:0] : brle8_pkg::CUR_W'(h - 1);
        endfunction

        function logic [brle8_pkg::CUR_W-1:0] sat_add(logic [brle8_pkg::CUR_W-1:0] a,
                                                      logic [7:0] d);
            int unsigned s;
            s = a + d;
            return (s > brle8_pkg::CUR_MAX) ? brle8_pkg::CUR_MAX
                                            : s[brle8_pkg::CUR_W-1:0];
        endfunction

        function void fill(int unsigned count, logic [7:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned n;
            t_segment    seg;
            w = used_width();
            h = used_height();
            while (count > 0) begin
                if (col >= w) next_line();
                n = w - col;
                if (n > count) n = count;
                if (row < h && byte_segs.size() < 33) begin
                    seg.row    = row[brle8_pkg::POS_W-1:0];
                    seg.column = col[brle8_pkg::POS_W-1:0];
                    seg.length = n[7:0];
                    seg.pixel  = pix;
                    seg.last   = 1'b0;
                    byte_segs.push_back(seg);
                end
                col   = col + n[brle8_pkg::CUR_W-1:0];
                count = count - n;
            end
        endfunction

        // advance the parser by one accepted item and queue what it writes
        function void decode_byte(logic [7:0] b, logic eod);
            byte_segs.delete();
            case (phase)
                EXPECT_VALUE: begin
                    phase = EXPECT_COUNT;
                    if (run_len != 0) begin
                        fill(run_len, b);
                    end else if (b == brle8_pkg::ESC_EOL) begin
                        next_line();
                    end else if (b == brle8_pkg::ESC_DELTA) begin
                        phase = EXPECT_DX;
                    end else if (b > brle8_pkg::ESC_DELTA) begin
                        lit_left = b;
                        pad_due  = b[0];
                        phase    = IN_LITERAL;
                    end
                end
                EXPECT_DX: begin
                    dx_hold = b;
                    phase   = EXPECT_DY;
                end
                EXPECT_DY: begin
                    col   = sat_add(col, dx_hold);
                    row   = sat_add(row, b);
                    phase = EXPECT_COUNT;
                end
                IN_LITERAL: begin
                    fill(1, b);
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 0) phase = pad_due ? EXPECT_PAD : EXPECT_COUNT;
                end
                EXPECT_PAD: begin
                    pad_due = 1'b0;
                    phase   = EXPECT_COUNT;
                end
                default: begin
                    run_len = b;
                    phase   = EXPECT_VALUE;
                end
            endcase
            if (byte_segs.size() > 0) byte_segs[byte_segs.size() - 1].last = 1'b1;
            foreach (byte_segs[i]) expected_segments.push_back(byte_segs[i]);
            if (eod) clear_stream();
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("segment %0d: %s is %0d, expected %0d",
                                 checked, name, got, want));
        endtask

        task check_segment(t_segment got);
            t_segment want;
            if (expected_segments.size() == 0) begin
                report($sformatf("unexpected segment row %0d col %0d len %0d pix %0d",
                                 got.row, got.column, got.length, got.pixel));
                return;
            end
            want = expected_segments.pop_front();
            checked++;
            compare_field("row", got.row, want.row);
            compare_field("column", got.column, want.column);
            compare_field("length", got.length, want.length);
            compare_field("pixel", got.pixel, want.pixel);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    brle8_in_if  in_ch();
    brle8_out_if out_ch();
    brle8_cfg_if cfg_ch();

    bmp_rle8_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_seg_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int stream_bytes   = 0;
    int settings_used  = 1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_segment({out_ch.row, out_ch.column, out_ch.length,
                              out_ch.pixel, out_ch.last});
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_data <= eod;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.decode_byte(b, eod);
        stream_bytes++;
    endtask

    task automatic send_bytes(logic [7:0] seq[$], int cut, logic eod_last);
        for (int i = 0; i < cut; i++) send_byte(seq[i], eod_last && (i == cut - 1));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [brle8_pkg::CUR_W-1:0] w,
                                logic [brle8_pkg::CUR_W-1:0] h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= brle8_pkg::REG_WIDTH;
        cfg_ch.data  <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_register(brle8_pkg::REG_WIDTH, w);
        cfg_ch.index <= brle8_pkg::REG_HEIGHT;
        cfg_ch.data  <= h;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_register(brle8_pkg::REG_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // one well-formed sequence with random content, or noise; sometimes cut
    // short or closed by end of data
    task automatic run_sequence(bit burst);
        logic [7:0] seq[$];
        int         pick;
        int         len;
        int         cut;
        int         ending;
        pick = $urandom_range(99);
        if (burst) begin
            repeat (9) begin
                seq.push_back(ESC_MARK);
                seq.push_back(brle8_pkg::ESC_DELTA);
                seq.push_back(8'd255);
                seq.push_back(8'd255);
            end
            seq.push_back(8'd5);
            seq.push_back(8'($urandom));
        end else if (pick < 35) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
            seq.push_back(8'(len));
            seq.push_back(8'($urandom));
        end else if (pick < 50) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
            seq.push_back(ESC_MARK);
            seq.push_back(8'(len));
            repeat (len) seq.push_back(8'($urandom));
            if (len % 2) seq.push_back(8'($urandom));
        end else if (pick < 60) begin
            seq.push_back(ESC_MARK);
            seq.push_back(brle8_pkg::ESC_EOL);
        end else if (pick < 65) begin
            seq.push_back(ESC_MARK);
            seq.push_back(brle8_pkg::ESC_EOB);
        end else if (pick < 85) begin
            seq.push_back(ESC_MARK);
            seq.push_back(brle8_pkg::ESC_DELTA);
            seq.push_back(($urandom_range(7) == 0) ? 8'd255 : 8'($urandom_range(0, 15)));
            seq.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
        end else begin
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
        end
        ending = $urandom_range(9);
        cut = (ending == 0) ? $urandom_range(1, seq.size()) : seq.size();
        send_bytes(seq, cut, ending <= 1);
    endtask

    task automatic run_phase(logic [brle8_pkg::CUR_W-1:0] w,
                             logic [brle8_pkg::CUR_W-1:0] h,
                             int send_pct, int stall_pct, int n, bit burst);
        int start;
        drain();
        write_config(w, h);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start = stream_bytes;
        if (burst) run_sequence(1'b1);
        while (stream_bytes - start < n) run_sequence(1'b0);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.end_of_data  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= brle8_pkg::REG_WIDTH;
        cfg_ch.data        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: a 255-pixel run, then one that wraps past column 320
        send_bytes('{8'd255, 8'h5A, 8'd100, 8'h3C}, 4, 1'b1);

        // narrow, short image: odd literal run with pad, 33-segment run with row
        // clamp, newline, end of bitmap, delta past the last row (dropped part),
        // then a literal run abandoned by end of data
        drain();
        write_config(11'd8, 11'd4);
        send_bytes('{8'd3, 8'h00,
                     ESC_MARK, 8'd3, 8'hFF, 8'h01, 8'h80, 8'h00,
                     8'd255, 8'hC3,
                     ESC_MARK, brle8_pkg::ESC_EOL,
                     ESC_MARK, brle8_pkg::ESC_EOB,
                     ESC_MARK, brle8_pkg::ESC_DELTA, 8'd6, 8'd5,
                     8'd3, 8'h99,
                     ESC_MARK, 8'd4, 8'h12}, 23, 1'b1);

        run_phase(11'd0,    11'd1,    0,  0,  20, 1'b0);
        run_phase(11'd2047, 11'd2047, 45, 0,  20, 1'b0);
        run_phase(11'd1024, 11'd0,    0,  45, 20, 1'b0);
        run_phase(11'd8,    11'd1024, 21, 21, 40, 1'b1);
        run_phase(11'($urandom_range(8, 64)), 11'($urandom_range(1, 16)),
                  0, 0, 20, 1'b0);
        drain();

        $display("Sent %0d stream bytes under %0d image sizes and four idling mixes;",
                 stream_bytes, settings_used);
        $display("%0d fill segments compared, %0d mismatches.",
                 sb.checked, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
